>>> design/tterc_pkg.sv
// Shared types and constants for the three-term recurrence checksum unit.
package tterc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TERM_W  = 16;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned COEF_W  = 8;
  // (byte + alpha) is 9 bits, times a 16-bit term
  localparam int unsigned SUM_W   = BYTE_W + 1;
  localparam int unsigned PPOS_W  = SUM_W + TERM_W;
  localparam int unsigned PNEG_W  = COEF_W + TERM_W;
  localparam int unsigned DIFF_W  = PPOS_W + 1;

  localparam logic [COEF_W-1:0] ALPHA_MULT   = COEF_W'(17);
  localparam logic [COEF_W-1:0] BETA_MULT    = COEF_W'(31);
  localparam logic [TERM_W-1:0] START_OFFSET = TERM_W'(7);
  localparam logic [TERM_W-1:0] TERM_INIT    = TERM_W'(1);
  localparam logic [TERM_W-1:0] CK_MOD       = TERM_W'(65535);

  typedef struct packed {
    logic              last_byte;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  // Input stage to core: one held byte and its flag
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

>>> design/tterc_if.sv
// Valid/ready channel interfaces for message bytes and checksum results.
interface tterc_in_if;
  logic                          valid;
  logic                          ready;
  logic [tterc_pkg::BYTE_W-1:0]  data_byte;
  logic                          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tterc_out_if;
  logic                          valid;
  logic                          ready;
  logic [tterc_pkg::TERM_W-1:0]  checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

>>> design/tterc_in_stage.sv
// Input register stage: holds one accepted byte until the core takes it.
module tterc_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  tterc_in_if.sink            in_chan,
  input  logic                take,
  output tterc_pkg::stage_t   stage
);

  logic                  valid_r, valid_nxt;
  tterc_pkg::in_item_t   item_r, item_nxt;
  logic                  accept;

  assign in_chan.ready = !valid_r || take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt          = 1'b1;
      item_nxt.data_byte = in_chan.data_byte;
      item_nxt.last_byte = in_chan.last_byte;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

>>> design/tterc_term_calc.sv
// Next recurrence term: ((byte + alpha) * cur - beta * prev) mod 65535, plus one when the difference is negative.
module tterc_term_calc (
  input  logic [tterc_pkg::BYTE_W-1:0] data_byte,
  input  logic [tterc_pkg::POS_W-1:0]  position,
  input  logic [tterc_pkg::TERM_W-1:0] cur_term,
  input  logic [tterc_pkg::TERM_W-1:0] prev_term,
  output logic [tterc_pkg::TERM_W-1:0] next_term
);

  logic [tterc_pkg::COEF_W-1:0]   alpha, beta;
  logic [tterc_pkg::SUM_W-1:0]    byte_sum;
  logic [tterc_pkg::PPOS_W-1:0]   pos_part;
  logic [tterc_pkg::PNEG_W-1:0]   neg_part;
  logic [tterc_pkg::DIFF_W-1:0]   diff;
  logic                           negative;
  logic [tterc_pkg::PPOS_W-1:0]   mag;
  logic [tterc_pkg::TERM_W:0]     fold1;
  logic [tterc_pkg::TERM_W-1:0]   fold2, signed_res;

  always_comb begin
    // mod 256 coefficients: keep the low byte of the product
    alpha    = tterc_pkg::COEF_W'(position * tterc_pkg::ALPHA_MULT);
    beta     = tterc_pkg::COEF_W'(position * tterc_pkg::BETA_MULT);
    byte_sum = tterc_pkg::SUM_W'(data_byte) + tterc_pkg::SUM_W'(alpha);
    pos_part = tterc_pkg::PPOS_W'(byte_sum) * tterc_pkg::PPOS_W'(cur_term);
    neg_part = tterc_pkg::PNEG_W'(beta) * tterc_pkg::PNEG_W'(prev_term);
    diff     = tterc_pkg::DIFF_W'(pos_part) - tterc_pkg::DIFF_W'(neg_part);
    negative = diff[tterc_pkg::DIFF_W-1];
    // negative: ~diff is |d| - 1, which is what the 26-bit wrap leaves
    mag      = negative ? ~diff[tterc_pkg::PPOS_W-1:0] : diff[tterc_pkg::PPOS_W-1:0];
    // 2^16 == 1 mod 65535: end-around fold, twice
    fold1    = (tterc_pkg::TERM_W+1)'(mag[tterc_pkg::TERM_W-1:0])
             + (tterc_pkg::TERM_W+1)'(mag[tterc_pkg::PPOS_W-1:tterc_pkg::TERM_W]);
    fold2    = fold1[tterc_pkg::TERM_W-1:0] + tterc_pkg::TERM_W'(fold1[tterc_pkg::TERM_W]);
    // negate mod 65535 by complement; all-ones stands for zero
    signed_res = negative ? ~fold2 : fold2;
    next_term  = (signed_res == tterc_pkg::CK_MOD) ? '0 : signed_res;
  end

endmodule

>>> design/three_term_recurrence_checksum_unit.sv
// Three-term recurrence checksum unit: top level with term state and result register.
//
// Takes a message one byte per transaction on in_chan (last_byte marks the
// final byte) and returns one 16-bit checksum per message on out_chan. The
// first byte sets the current term to byte + 7 with the previous term at 1;
// each later byte at position i folds ((byte + 17i) * cur - (31i) * prev),
// plus one if negative, into the range 0..65534, with coefficients taken
// mod 256. A byte is accepted every clock cycle while results are being
// drained. The last byte lands in the input register when it is accepted,
// and the checksum lands in the result register when the core takes that
// byte, which raises out_chan.valid. Throughput is one byte per cycle while
// results are drained, set by the term update loop: two narrow multipliers
// and an end-around mod-65535 fold between the term registers and back. A
// byte carrying last_byte waits in the input register only while a previous
// checksum is still unclaimed.
module three_term_recurrence_checksum_unit (
  input  logic       clk,
  input  logic       rst_n,
  tterc_in_if.sink   in_chan,
  tterc_out_if.source out_chan
);

  tterc_pkg::stage_t               stage;
  logic                            take;

  // recurrence state
  logic [tterc_pkg::TERM_W-1:0]    prev_r, prev_nxt;
  logic [tterc_pkg::TERM_W-1:0]    cur_r, cur_nxt;
  logic [tterc_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic                            at_start_r, at_start_nxt;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  logic [tterc_pkg::TERM_W-1:0]    checksum_r, checksum_nxt;

  logic [tterc_pkg::TERM_W-1:0]    calc_term;
  logic [tterc_pkg::TERM_W-1:0]    new_cur, new_prev;

  tterc_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .stage   (stage)
  );

  tterc_term_calc u_term_calc (
    .data_byte (stage.item.data_byte),
    .position  (pos_r),
    .cur_term  (cur_r),
    .prev_term (prev_r),
    .next_term (calc_term)
  );

  // Non-final bytes always move on; a final byte needs the result slot free
  assign take = stage.valid &&
                (!stage.item.last_byte || !out_valid_r || out_chan.ready);

  always_comb begin
    if (at_start_r) begin
      new_cur  = tterc_pkg::TERM_W'(stage.item.data_byte) + tterc_pkg::START_OFFSET;
      new_prev = tterc_pkg::TERM_INIT;
    end else begin
      new_cur  = calc_term;
      new_prev = cur_r;
    end
  end

  always_comb begin
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    at_start_nxt  = at_start_r;
    checksum_nxt  = checksum_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (take) begin
      if (stage.item.last_byte) begin
        // emit and rearm for the next message
        checksum_nxt  = new_cur;
        out_valid_nxt = 1'b1;
        prev_nxt      = tterc_pkg::TERM_INIT;
        cur_nxt       = tterc_pkg::TERM_INIT;
        pos_nxt       = '0;
        at_start_nxt  = 1'b1;
      end else begin
        prev_nxt      = new_prev;
        cur_nxt       = new_cur;
        pos_nxt       = pos_r + tterc_pkg::POS_W'(1);
        at_start_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= tterc_pkg::TERM_INIT;
      cur_r       <= tterc_pkg::TERM_INIT;
      pos_r       <= '0;
      at_start_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      cur_r       <= cur_nxt;
      pos_r       <= pos_nxt;
      at_start_r  <= at_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    checksum_r <= checksum_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.checksum = checksum_r;

endmodule
